// ----- rtl/core/srlrd_pkg.sv -----
package srlrd_pkg;

	localparam int MASK_W  = 16;
	localparam int LEN_W   = 5;
	localparam int START_W = 4;
	localparam int HALF_W  = 5;
	localparam int CDEG_W  = 16;

	localparam int CENTIDEG_FULL = 36000;

endpackage

// ----- rtl/core/sensor_ring_longest_run_direction_core.sv -----
// Longest circular run of active detectors on a ring of SENSOR_COUNT equally spaced detectors,
// with the run's length, first detector and midpoint direction (half-detector steps and rounded
// hundredths of a degree). Ties go to the run that starts at the lowest detector. One mask is
// accepted per cycle while mask_stall is low. The four stages are the input
// register, the per-detector run lengths (log2 doubling steps), the best-run selection tree
// and the output register for the angle arithmetic. Each stage holds while the one after it is
// full and stalled, so result_stall only reaches mask_stall once every stage is occupied.
// angle_valid is low when no detector or every detector is active; the angle fields are then 0.
module sensor_ring_longest_run_direction_core #(
	parameter int SENSOR_COUNT = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                mask_valid,
	output logic                                mask_stall,
	input  logic [srlrd_pkg::MASK_W-1:0]        sensor_mask,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [srlrd_pkg::LEN_W-1:0]         run_length,
	output logic [srlrd_pkg::START_W-1:0]       run_start,
	output logic [srlrd_pkg::HALF_W-1:0]        angle_half_steps,
	output logic [srlrd_pkg::CDEG_W-1:0]        angle_centideg,
	output logic                                angle_valid
);

	localparam int STEPS   = $clog2(SENSOR_COUNT);
	localparam int IDX_W   = STEPS;
	localparam int RL_W    = STEPS + 1;
	localparam int HIDX_W  = STEPS + 1;
	localparam int HF_W    = STEPS + 2;
	localparam int LEAVES  = 1 << STEPS;

	// pipeline control
	logic valid_s1, valid_s2, valid_s3;
	logic en1, en2, en3, en4;

	assign en4 = !result_valid || !result_stall;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign mask_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (en1) valid_s1 <= mask_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) result_valid <= valid_s3;
		end
	end

	// stage 1: input register
	logic [srlrd_pkg::MASK_W-1:0] mask_s1;

	always_ff @(posedge clk) begin
		if (en1 && mask_valid) mask_s1 <= sensor_mask;
	end

	// stage 2: run length from every run start, capped at ring size
	logic                ring [SENSOR_COUNT];
	logic [RL_W-1:0]     run_w [STEPS+1][SENSOR_COUNT];
	logic [RL_W-1:0]     len_w [SENSOR_COUNT];
	logic [RL_W-1:0]     len_s2 [SENSOR_COUNT];

	for (genvar gs = 0; gs < SENSOR_COUNT; gs++) begin : g_ring
		if (gs < srlrd_pkg::MASK_W) begin : g_in
			assign ring[gs] = mask_s1[gs];
		end else begin : g_off
			assign ring[gs] = 1'b0;
		end
		assign run_w[0][gs] = RL_W'(ring[gs]);
	end

	for (genvar gj = 0; gj < STEPS; gj++) begin : g_dbl
		for (genvar gs = 0; gs < SENSOR_COUNT; gs++) begin : g_pos
			localparam int NXT = (gs + (1 << gj)) % SENSOR_COUNT;
			assign run_w[gj+1][gs] = (run_w[gj][gs] == RL_W'(1 << gj)) ?
				run_w[gj][gs] + run_w[gj][NXT] : run_w[gj][gs];
		end
	end

	for (genvar gs = 0; gs < SENSOR_COUNT; gs++) begin : g_len
		logic head;
		logic [RL_W-1:0] capped;
		if (gs == 0) begin : g_first
			assign head = ring[gs];
		end else begin : g_rest
			assign head = ring[gs] && !ring[gs-1];
		end
		assign capped = (run_w[STEPS][gs] > RL_W'(SENSOR_COUNT)) ?
			RL_W'(SENSOR_COUNT) : run_w[STEPS][gs];
		assign len_w[gs] = head ? capped : '0;
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) len_s2 <= len_w;
	end

	// stage 3: longest run, lowest start wins a tie
	logic [RL_W-1:0]  node_len [2*LEAVES];
	logic [IDX_W-1:0] node_idx [2*LEAVES];
	logic [RL_W-1:0]  best_len_s3;
	logic [IDX_W-1:0] best_start_s3;

	assign node_len[0] = '0;
	assign node_idx[0] = '0;

	for (genvar gl = 0; gl < LEAVES; gl++) begin : g_leaf
		if (gl < SENSOR_COUNT) begin : g_used
			assign node_len[LEAVES+gl] = len_s2[gl];
		end else begin : g_pad
			assign node_len[LEAVES+gl] = '0;
		end
		assign node_idx[LEAVES+gl] = IDX_W'(gl);
	end

	for (genvar gn = 1; gn < LEAVES; gn++) begin : g_node
		logic take_right;
		assign take_right = node_len[2*gn+1] > node_len[2*gn];
		assign node_len[gn] = take_right ? node_len[2*gn+1] : node_len[2*gn];
		assign node_idx[gn] = take_right ? node_idx[2*gn+1] : node_idx[2*gn];
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			best_len_s3   <= node_len[1];
			best_start_s3 <= node_idx[1];
		end
	end

	// stage 4: midpoint direction
	logic [srlrd_pkg::CDEG_W-1:0] cdeg_lut [2*SENSOR_COUNT];

	for (genvar gh = 0; gh < 2*SENSOR_COUNT; gh++) begin : g_lut
		assign cdeg_lut[gh] = srlrd_pkg::CDEG_W'(
			(gh * srlrd_pkg::CENTIDEG_FULL + SENSOR_COUNT) / (2 * SENSOR_COUNT));
	end

	logic              dir_ok;
	logic [HF_W-1:0]   half_full;
	logic [HIDX_W-1:0] half;

	always_comb begin
		dir_ok    = (best_len_s3 != '0) && (best_len_s3 < RL_W'(SENSOR_COUNT));
		half_full = (HF_W'(best_start_s3) << 1) + HF_W'(best_len_s3) - HF_W'(1);
		if (half_full >= HF_W'(2 * SENSOR_COUNT)) begin
			half = HIDX_W'(half_full - HF_W'(2 * SENSOR_COUNT));
		end else begin
			half = HIDX_W'(half_full);
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && valid_s3) begin
			run_length  <= srlrd_pkg::LEN_W'(best_len_s3);
			run_start   <= (best_len_s3 != '0) ? srlrd_pkg::START_W'(best_start_s3) : '0;
			angle_valid <= dir_ok;
			if (dir_ok) begin
				angle_half_steps <= srlrd_pkg::HALF_W'(half);
				angle_centideg   <= cdeg_lut[half];
			end else begin
				angle_half_steps <= '0;
				angle_centideg   <= '0;
			end
		end
	end

endmodule
